// File: rtl/core/fmsls_pkg.sv
// fm seek lock scanner shared types, constants and codes
`timescale 1ns / 1ps

package fmsls_pkg;

    localparam int FREQ_W     = 14;
    localparam int DEV_W      = 12;
    localparam int SNR_W      = 4;
    localparam int RSSI_W     = 8;
    localparam int SLOT_W     = 5;
    localparam int SPACING_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [SLOT_W-1:0] CHANNEL_SLOTS = 5'd20;

    localparam logic [FREQ_W-1:0] FREQ_MIN = 14'd6400;
    localparam logic [FREQ_W-1:0] FREQ_MAX = 14'd10800;

    localparam logic [DEV_W-1:0] DEV_BAND_LO = 12'd280;
    localparam logic [DEV_W-1:0] DEV_BAND_HI = 12'd3815;
    localparam logic [DEV_W-1:0] DEV_POS_MIN = 12'd20;
    localparam logic [DEV_W-1:0] DEV_NEG_MAX = 12'd4075;
    localparam int               DEV_SIGN    = 11;

    localparam logic [SPACING_W-1:0] SPACING_200K = 2'd0;
    localparam logic [SPACING_W-1:0] SPACING_100K = 2'd1;

    localparam logic [4:0] STEP_200K = 5'd20;
    localparam logic [4:0] STEP_100K = 5'd10;
    localparam logic [4:0] STEP_50K  = 5'd5;

    localparam logic [CFG_IDX_W-1:0] REG_SPACING_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SNR_THRESHOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RSSI_THRESHOLD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_SCAN      = 2'd3;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_MEASURE = 1'b1;

    typedef struct packed {
        logic [SPACING_W-1:0] spacing_mode;
        logic [SNR_W-1:0]     snr_threshold;
        logic [RSSI_W-1:0]    rssi_threshold;
        logic                 auto_scan;
    } cfg_t;

    typedef struct packed {
        logic [FREQ_W-1:0] current_frequency;
        logic [FREQ_W-1:0] base_frequency;
        logic [DEV_W-1:0]  last_deviation;
        logic              step_down;
        logic              scanning;
        logic [SLOT_W-1:0] slot_position;
    } state_t;

    typedef struct packed {
        logic              opcode;
        logic [FREQ_W-1:0] start_freq;
        logic              direction;
        logic [SNR_W-1:0]  snr;
        logic [RSSI_W-1:0] rssi;
        logic              afc_railed;
        logic [DEV_W-1:0]  deviation;
    } item_t;

    typedef struct packed {
        logic [FREQ_W-1:0] tune_frequency;
        logic              locked;
        logic              store_valid;
        logic [SLOT_W-1:0] store_slot;
        logic              scan_active;
        logic              scan_done;
    } result_t;

endpackage

// File: rtl/core/fmsls_if.sv
// handshake channel interfaces for commands, results and configuration writes
`timescale 1ns / 1ps

interface fmsls_cmd_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [fmsls_pkg::FREQ_W-1:0]  start_freq;
    logic                          direction;
    logic [fmsls_pkg::SNR_W-1:0]   snr;
    logic [fmsls_pkg::RSSI_W-1:0]  rssi;
    logic                          afc_railed;
    logic [fmsls_pkg::DEV_W-1:0]   deviation;

    modport source (output valid, opcode, start_freq, direction, snr, rssi, afc_railed,
                    deviation, input ready);
    modport sink (input valid, opcode, start_freq, direction, snr, rssi, afc_railed,
                  deviation, output ready);
endinterface

interface fmsls_res_if;
    logic                          valid;
    logic                          ready;
    logic [fmsls_pkg::FREQ_W-1:0]  tune_frequency;
    logic                          locked;
    logic                          store_valid;
    logic [fmsls_pkg::SLOT_W-1:0]  store_slot;
    logic                          scan_active;
    logic                          scan_done;

    modport source (output valid, tune_frequency, locked, store_valid, store_slot,
                    scan_active, scan_done, input ready);
    modport sink (input valid, tune_frequency, locked, store_valid, store_slot,
                  scan_active, scan_done, output ready);
endinterface

interface fmsls_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [fmsls_pkg::CFG_IDX_W-1:0]   index;
    logic [fmsls_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/fmsls_core.sv
// lock test, frequency stepping and scan control for one item
`timescale 1ns / 1ps

module fmsls_core (
    input  fmsls_pkg::cfg_t    cfg,
    input  fmsls_pkg::state_t  state,
    input  fmsls_pkg::item_t   item,
    output fmsls_pkg::state_t  state_next,
    output fmsls_pkg::result_t result
);

    logic [4:0]                   spacing;
    logic [fmsls_pkg::FREQ_W-1:0] step_src;
    logic                         step_dir;
    logic [fmsls_pkg::FREQ_W:0]   step_sum;
    logic                         step_borrow;
    logic [fmsls_pkg::FREQ_W-1:0] stepped;
    logic [fmsls_pkg::FREQ_W:0]   cur_plus;
    logic [fmsls_pkg::FREQ_W:0]   base_plus;
    logic                         dev_in_band;
    logic                         above_base_bad;
    logic                         below_base_bad;
    logic                         lock_ok;
    logic                         stop;
    logic [fmsls_pkg::SLOT_W-1:0] slot_inc;

    always_comb
    begin
        case (cfg.spacing_mode)
            fmsls_pkg::SPACING_200K: spacing = fmsls_pkg::STEP_200K;
            fmsls_pkg::SPACING_100K: spacing = fmsls_pkg::STEP_100K;
            default:                 spacing = fmsls_pkg::STEP_50K;
        endcase
    end

    // one shared stepper: start steps from start_freq, measurement from current
    assign step_src = (item.opcode == fmsls_pkg::OP_START) ? item.start_freq
                                                           : state.current_frequency;
    assign step_dir = (item.opcode == fmsls_pkg::OP_START) ? item.direction : state.step_down;

    always_comb
    begin
        step_borrow = step_dir && (step_src < {{(fmsls_pkg::FREQ_W-5){1'b0}}, spacing});
        if (step_dir)
        begin
            step_sum = {1'b0, step_src} - {{(fmsls_pkg::FREQ_W-4){1'b0}}, spacing};
        end
        else
        begin
            step_sum = {1'b0, step_src} + {{(fmsls_pkg::FREQ_W-4){1'b0}}, spacing};
        end
        // a step below zero shows up as a borrow and lands on the low edge
        if (step_borrow)
        begin
            stepped = fmsls_pkg::FREQ_MIN;
        end
        else if (step_sum < {1'b0, fmsls_pkg::FREQ_MIN})
        begin
            stepped = fmsls_pkg::FREQ_MAX;
        end
        else if (step_sum > {1'b0, fmsls_pkg::FREQ_MAX})
        begin
            stepped = fmsls_pkg::FREQ_MIN;
        end
        else
        begin
            stepped = step_sum[fmsls_pkg::FREQ_W-1:0];
        end
    end

    assign cur_plus  = {1'b0, state.current_frequency}
                     + {{(fmsls_pkg::FREQ_W-4){1'b0}}, spacing};
    assign base_plus = {1'b0, state.base_frequency}
                     + {{(fmsls_pkg::FREQ_W-4){1'b0}}, spacing};

    assign dev_in_band = (item.deviation >= fmsls_pkg::DEV_BAND_LO)
                      && (item.deviation <= fmsls_pkg::DEV_BAND_HI);

    // previous step's deviation must point toward the current frequency
    assign above_base_bad = (state.current_frequency > fmsls_pkg::FREQ_MIN)
                         && ({1'b0, state.current_frequency} == base_plus)
                         && (state.last_deviation[fmsls_pkg::DEV_SIGN]
                             || (state.last_deviation < fmsls_pkg::DEV_POS_MIN));
    assign below_base_bad = (state.current_frequency >= fmsls_pkg::FREQ_MIN)
                         && ({1'b0, state.base_frequency} == cur_plus)
                         && (!state.last_deviation[fmsls_pkg::DEV_SIGN]
                             || (state.last_deviation > fmsls_pkg::DEV_NEG_MAX));

    assign lock_ok = (item.snr > cfg.snr_threshold)
                  && !item.afc_railed
                  && (item.rssi >= cfg.rssi_threshold)
                  && !dev_in_band
                  && !above_base_bad
                  && !below_base_bad;

    assign slot_inc = state.slot_position + 1'b1;

    always_comb
    begin
        state_next = state;
        result     = '0;
        stop       = 1'b0;
        if (item.opcode == fmsls_pkg::OP_START)
        begin
            state_next.step_down         = item.direction;
            state_next.slot_position     = '0;
            state_next.scanning          = 1'b1;
            state_next.current_frequency = stepped;
        end
        else
        begin
            result.locked             = lock_ok;
            state_next.last_deviation = item.deviation;
            state_next.base_frequency = state.current_frequency;
            if (state.scanning)
            begin
                if (lock_ok)
                begin
                    if (!cfg.auto_scan)
                    begin
                        stop = 1'b1;
                    end
                    else
                    begin
                        if (state.slot_position < fmsls_pkg::CHANNEL_SLOTS)
                        begin
                            result.store_valid       = 1'b1;
                            result.store_slot        = state.slot_position;
                            state_next.slot_position = slot_inc;
                            if (slot_inc >= fmsls_pkg::CHANNEL_SLOTS)
                            begin
                                stop = 1'b1;
                            end
                        end
                        else
                        begin
                            stop = 1'b1;
                        end
                    end
                end
                if (!stop)
                begin
                    if (cfg.auto_scan && (state.current_frequency >= fmsls_pkg::FREQ_MAX))
                    begin
                        stop = 1'b1;
                    end
                    else
                    begin
                        state_next.current_frequency = stepped;
                    end
                end
                if (stop)
                begin
                    state_next.scanning = 1'b0;
                    result.scan_done    = 1'b1;
                end
            end
        end
        result.tune_frequency = state_next.current_frequency;
        result.scan_active    = state_next.scanning;
    end

endmodule

// File: rtl/core/fm_seek_lock_scanner.sv
// fm seek lock scanner top level: channel registers, scan state and config registers
`timescale 1ns / 1ps

// Takes one command per clock, back to back, while the res side does not stall,
// and returns one result per command. A command is held in the input register
// while the lock test, the frequency step and the scan decision are made against
// the scan state, and the result lands in the output register, which drives res
// valid, once that register is free or drains. The result register lets the next
// command be taken while a result still waits, so a stalled res side holds two
// commands, the waiting result and one in the input register, before cmd ready
// drops. Configuration writes take effect on the cycle after their transfer and
// are meant to be made while no command is in flight. Opcode 0 starts a scan one
// spacing away from start_freq; opcode 1 reports a measurement at the tuned
// frequency.
module fm_seek_lock_scanner (
    input  logic         clk,
    input  logic         rst_n,
    fmsls_cfg_if.sink    cfg,
    fmsls_cmd_if.sink    cmd,
    fmsls_res_if.source  res
);

    fmsls_pkg::cfg_t    cfg_reg;
    fmsls_pkg::state_t  state_reg;
    fmsls_pkg::state_t  state_next;
    fmsls_pkg::item_t   item_reg;
    fmsls_pkg::result_t result_reg;
    fmsls_pkg::result_t result_next;
    logic               item_valid_reg;
    logic               res_valid_reg;
    logic               advance;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.spacing_mode   <= fmsls_pkg::SPACING_200K;
            cfg_reg.snr_threshold  <= 4'd2;
            cfg_reg.rssi_threshold <= 8'd10;
            cfg_reg.auto_scan      <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                fmsls_pkg::REG_SPACING_MODE:
                    cfg_reg.spacing_mode <= cfg.data[fmsls_pkg::SPACING_W-1:0];
                fmsls_pkg::REG_SNR_THRESHOLD:
                    cfg_reg.snr_threshold <= cfg.data[fmsls_pkg::SNR_W-1:0];
                fmsls_pkg::REG_RSSI_THRESHOLD:
                    cfg_reg.rssi_threshold <= cfg.data[fmsls_pkg::RSSI_W-1:0];
                fmsls_pkg::REG_AUTO_SCAN:
                    cfg_reg.auto_scan <= cfg.data[0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // item moves to the result register when that register is free or drains
    assign advance   = item_valid_reg && (!res_valid_reg || res.ready);
    assign cmd.ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            item_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            item_reg.opcode     <= cmd.opcode;
            item_reg.start_freq <= cmd.start_freq;
            item_reg.direction  <= cmd.direction;
            item_reg.snr        <= cmd.snr;
            item_reg.rssi       <= cmd.rssi;
            item_reg.afc_railed <= cmd.afc_railed;
            item_reg.deviation  <= cmd.deviation;
        end
    end

    fmsls_core u_core (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.current_frequency <= fmsls_pkg::FREQ_MIN;
            state_reg.base_frequency    <= '0;
            state_reg.last_deviation    <= '0;
            state_reg.step_down         <= 1'b0;
            state_reg.scanning          <= 1'b0;
            state_reg.slot_position     <= '0;
            res_valid_reg               <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.tune_frequency = result_reg.tune_frequency;
    assign res.locked         = result_reg.locked;
    assign res.store_valid    = result_reg.store_valid;
    assign res.store_slot     = result_reg.store_slot;
    assign res.scan_active    = result_reg.scan_active;
    assign res.scan_done      = result_reg.scan_done;

`ifndef SYNTHESIS
    // the waiting result always reflects the scan state it left behind
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (result_reg.tune_frequency == state_reg.current_frequency))
        else $error("result frequency differs from tuned frequency");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (result_reg.scan_active == state_reg.scanning))
        else $error("result scan_active differs from scan state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && result_reg.store_valid)
            |-> (state_reg.slot_position == result_reg.store_slot + 5'd1))
        else $error("slot position did not follow the stored slot");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.current_frequency >= fmsls_pkg::FREQ_MIN)
            && (state_reg.current_frequency <= fmsls_pkg::FREQ_MAX))
        else $error("tuned frequency left the band");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && result_reg.scan_done)
            |-> (!result_reg.scan_active && !state_reg.scanning))
        else $error("scan reported done while still active");
`endif

endmodule

// File: bench/fmsls_checker.sv
`timescale 1ns / 1ps
// seek scanner checker: mirrors the config registers, predicts each result and compares

module fmsls_checker
    import fmsls_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    fmsls_cfg_if  cfg,
    fmsls_cmd_if  cmd,
    fmsls_res_if  res,
    output int    mismatches,
    output int    results_due
);

    cfg_t              seek_cfg;
    logic [FREQ_W-1:0] cur_freq;
    logic [FREQ_W-1:0] base_freq;
    logic [DEV_W-1:0]  last_dev;
    logic              step_dn;
    logic              scanning;
    logic [SLOT_W-1:0] slot_pos;
    result_t           pending_results[$];

    function automatic int channel_spacing();
        case (seek_cfg.spacing_mode)
            SPACING_200K: return int'(STEP_200K);
            SPACING_100K: return int'(STEP_100K);
            default:      return int'(STEP_50K);
        endcase
    endfunction

    // step modulo 2^16, then wrap into the band
    function automatic logic [FREQ_W-1:0] next_channel(logic [FREQ_W-1:0] f, logic down);
        logic [15:0] n;
        if (down)
            n = 16'(f) - 16'(channel_spacing());
        else
            n = 16'(f) + 16'(channel_spacing());
        if (n < FREQ_MIN)
            return FREQ_MAX;
        if (n > FREQ_MAX)
            return FREQ_MIN;
        return n[FREQ_W-1:0];
    endfunction

    task automatic predict_seek(input item_t it, output result_t r);
        int   f;
        int   b;
        int   s;
        logic pass;
        logic stop;
        r = '0;
        if (it.opcode == OP_START)
        begin
            step_dn  = it.direction;
            slot_pos = '0;
            scanning = 1'b1;
            cur_freq = next_channel(it.start_freq, it.direction);
        end
        else
        begin
            f    = int'(cur_freq);
            b    = int'(base_freq);
            s    = channel_spacing();
            pass = 1'b1;
            if (it.snr <= seek_cfg.snr_threshold)
                pass = 1'b0;
            else if (it.afc_railed || it.rssi < seek_cfg.rssi_threshold)
                pass = 1'b0;
            else if (it.deviation >= DEV_BAND_LO && it.deviation <= DEV_BAND_HI)
                pass = 1'b0;
            // stepped up from base: previous deviation must be positive and not tiny
            else if (f > int'(FREQ_MIN) && f == b + s
                     && (last_dev[DEV_SIGN] || last_dev < DEV_POS_MIN))
                pass = 1'b0;
            // stepped down from base: previous deviation must be clearly negative
            else if (f >= int'(FREQ_MIN) && b == f + s
                     && (!last_dev[DEV_SIGN] || last_dev > DEV_NEG_MAX))
                pass = 1'b0;
            last_dev  = it.deviation;
            base_freq = cur_freq;
            r.locked  = pass;
            stop      = 1'b0;
            if (scanning)
            begin
                if (pass)
                begin
                    if (!seek_cfg.auto_scan)
                        stop = 1'b1;
                    else
                    begin
                        if (slot_pos < CHANNEL_SLOTS)
                        begin
                            r.store_valid = 1'b1;
                            r.store_slot  = slot_pos;
                            slot_pos      = slot_pos + 1'b1;
                        end
                        if (slot_pos >= CHANNEL_SLOTS)
                            stop = 1'b1;
                    end
                end
                if (!stop)
                begin
                    if (seek_cfg.auto_scan && cur_freq >= FREQ_MAX)
                        stop = 1'b1;
                    else
                        cur_freq = next_channel(cur_freq, step_dn);
                end
                if (stop)
                begin
                    scanning    = 1'b0;
                    r.scan_done = 1'b1;
                end
            end
        end
        r.tune_frequency = cur_freq;
        r.scan_active    = scanning;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s, got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        item_t   it;
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            seek_cfg.spacing_mode   = SPACING_200K;
            seek_cfg.snr_threshold  = 4'd2;
            seek_cfg.rssi_threshold = 8'd10;
            seek_cfg.auto_scan      = 1'b0;
            cur_freq    = FREQ_MIN;
            base_freq   = '0;
            last_dev    = '0;
            step_dn     = 1'b0;
            scanning    = 1'b0;
            slot_pos    = '0;
            mismatches  = 0;
            results_due = 0;
            pending_results.delete();
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                got = {res.tune_frequency, res.locked, res.store_valid, res.store_slot,
                       res.scan_active, res.scan_done};
                if (pending_results.size() == 0)
                    report_mismatch("result transfer with nothing pending, tune_frequency",
                                    got.tune_frequency, -1);
                else
                begin
                    want = pending_results.pop_front();
                    if (got.tune_frequency !== want.tune_frequency)
                        report_mismatch("tune_frequency", got.tune_frequency,
                                        want.tune_frequency);
                    if (got.locked !== want.locked)
                        report_mismatch("locked", got.locked, want.locked);
                    if (got.store_valid !== want.store_valid)
                        report_mismatch("store_valid", got.store_valid, want.store_valid);
                    if (got.store_slot !== want.store_slot)
                        report_mismatch("store_slot", got.store_slot, want.store_slot);
                    if (got.scan_active !== want.scan_active)
                        report_mismatch("scan_active", got.scan_active, want.scan_active);
                    if (got.scan_done !== want.scan_done)
                        report_mismatch("scan_done", got.scan_done, want.scan_done);
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_SPACING_MODE:   seek_cfg.spacing_mode   = cfg.data[SPACING_W-1:0];
                    REG_SNR_THRESHOLD:  seek_cfg.snr_threshold  = cfg.data[SNR_W-1:0];
                    REG_RSSI_THRESHOLD: seek_cfg.rssi_threshold = cfg.data[RSSI_W-1:0];
                    REG_AUTO_SCAN:      seek_cfg.auto_scan      = cfg.data[0];
                    default: ;
                endcase
            end
            if (cmd.valid && cmd.ready)
            begin
                it = {cmd.opcode, cmd.start_freq, cmd.direction, cmd.snr, cmd.rssi,
                      cmd.afc_railed, cmd.deviation};
                predict_seek(it, want);
                pending_results.push_back(want);
            end
            results_due = pending_results.size();
        end
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// testbench top for the fm seek lock scanner: stimulus, flow control and verdict

module tb_top;
    import fmsls_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF       = 60;

    logic clk;
    logic rst_n;
    bit   idle_on;
    int   hold_left;
    int   snr_thr;
    int   rssi_thr;
    int   mismatches;
    int   results_due;

    fmsls_cfg_if cfg_ch ();
    fmsls_cmd_if cmd_ch ();
    fmsls_res_if res_ch ();

    fm_seek_lock_scanner u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    fmsls_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_ch),
        .cmd         (cmd_ch),
        .res         (res_ch),
        .mismatches  (mismatches),
        .results_due (results_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic item_t make_item(logic op, int freq, int dir, int snr, int rssi,
                                        int railed, int dev);
        item_t it;
        it.opcode     = op;
        it.start_freq = FREQ_W'(freq);
        it.direction  = 1'(dir);
        it.snr        = SNR_W'(snr);
        it.rssi       = RSSI_W'(rssi);
        it.afc_railed = 1'(railed);
        it.deviation  = DEV_W'(dev);
        return it;
    endfunction

    function automatic item_t random_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(item_t)-1:0];
    endfunction

    function automatic item_t make_start();
        item_t it;
        int    pick;
        it        = random_item();
        it.opcode = OP_START;
        pick      = $urandom_range(0, 9);
        if (pick < 6)
            it.start_freq = FREQ_W'($urandom_range(FREQ_MIN, FREQ_MAX));
        else if (pick == 6)
            it.start_freq = FREQ_W'($urandom_range(FREQ_MAX - 40, FREQ_MAX));
        else if (pick == 7)
            it.start_freq = FREQ_W'($urandom_range(FREQ_MIN, FREQ_MIN + 40));
        else if (pick == 8)
            it.start_freq = FREQ_W'($urandom_range(0, 30));
        return it;
    endfunction

    // a well-formed measurement passes the rssi, afc and band checks, and the snr check while its threshold is below 15
    function automatic item_t make_measure(bit well_formed);
        item_t it;
        it        = random_item();
        it.opcode = OP_MEASURE;
        if (well_formed)
        begin
            if (snr_thr < 15)
                it.snr = SNR_W'($urandom_range(snr_thr + 1, 15));
            it.rssi       = RSSI_W'($urandom_range(rssi_thr, 255));
            it.afc_railed = 1'b0;
            if ($urandom_range(0, 1))
                it.deviation = DEV_W'($urandom_range(0, DEV_BAND_LO - 1));
            else
                it.deviation = DEV_W'($urandom_range(DEV_BAND_HI + 1, 4095));
        end
        return it;
    endfunction

    task automatic send_cmd(input item_t it);
        int gap;
        gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            cmd_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_ch.valid      <= 1'b1;
        cmd_ch.opcode     <= it.opcode;
        cmd_ch.start_freq <= it.start_freq;
        cmd_ch.direction  <= it.direction;
        cmd_ch.snr        <= it.snr;
        cmd_ch.rssi       <= it.rssi;
        cmd_ch.afc_railed <= it.afc_railed;
        cmd_ch.deviation  <= it.deviation;
        do @(posedge clk); while (!cmd_ch.ready);
    endtask

    // stop offering and wait until every result is back, then let the pipeline settle
    task automatic drain();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (results_due != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= CFG_DATA_W'(value);
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic apply_settings(input int spacing, input int snr, input int rssi,
                                  input int auto_mode);
        write_reg(REG_SPACING_MODE, spacing);
        write_reg(REG_SNR_THRESHOLD, snr);
        write_reg(REG_RSSI_THRESHOLD, rssi);
        write_reg(REG_AUTO_SCAN, auto_mode);
        snr_thr  = snr;
        rssi_thr = rssi;
    endtask

    // mostly scans with random measurements behind them, some stray items
    task automatic run_phase(input int n);
        int sent;
        int len;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_cmd(random_item());
                sent++;
            end
            else
            begin
                send_cmd(make_start());
                len = $urandom_range(1, 50);
                repeat (len) send_cmd(make_measure($urandom_range(0, 9) < 6));
                sent += len + 1;
            end
            if ($urandom_range(0, 29) == 0)
                drain();
        end
    endtask

    // result side flow control
    initial
    begin : receiver
        int stall_left;
        stall_left   = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 18);
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[fm_seek_lock_scanner] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        cmd_ch.valid      = 1'b0;
        cmd_ch.opcode     = OP_START;
        cmd_ch.start_freq = '0;
        cmd_ch.direction  = 1'b0;
        cmd_ch.snr        = '0;
        cmd_ch.rssi       = '0;
        cmd_ch.afc_railed = 1'b0;
        cmd_ch.deviation  = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = REG_SPACING_MODE;
        cfg_ch.data       = '0;
        idle_on   = 1'b1;
        hold_left = 0;
        snr_thr   = 2;
        rssi_thr  = 10;
        rst_n     = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: 200 kHz steps, manual stop
        send_cmd(make_item(OP_MEASURE, 0, 0, 15, 255, 0, 0));       // lock test while idle
        send_cmd(make_item(OP_MEASURE, 0, 0, 15, 255, 1, 4095));    // afc railed, idle
        send_cmd(make_item(OP_START, FREQ_MIN, 1, 0, 0, 0, 0));      // down past bottom
        send_cmd(make_item(OP_MEASURE, 0, 0, 2, 255, 0, 0));        // snr at threshold
        send_cmd(make_item(OP_MEASURE, 0, 0, 15, 9, 0, 0));         // rssi just below
        send_cmd(make_item(OP_MEASURE, 0, 0, 15, 255, 0, 280));
        send_cmd(make_item(OP_MEASURE, 0, 0, 15, 255, 0, 3815));
        send_cmd(make_item(OP_MEASURE, 0, 0, 3, 10, 0, 3816));      // lock ends manual scan
        send_cmd(make_item(OP_START, FREQ_MAX, 0, 15, 255, 1, 4095)); // up past top
        send_cmd(make_item(OP_MEASURE, 0, 0, 15, 255, 0, 279));
        send_cmd(make_item(OP_START, 0, 1, 0, 0, 0, 0));             // start below spacing
        send_cmd(make_item(OP_START, 16383, 0, 0, 0, 0, 0));
        send_cmd(make_item(OP_START, 10790, 0, 0, 0, 0, 0));
        send_cmd(make_item(OP_MEASURE, 16383, 1, 15, 255, 0, 2048));
        send_cmd(make_item(OP_MEASURE, 0, 0, 15, 255, 0, 4095));
        send_cmd(make_item(OP_MEASURE, 0, 0, 15, 255, 0, 19));
        send_cmd(make_item(OP_MEASURE, 0, 0, 15, 255, 0, 20));
        drain();

        // auto store with open thresholds: fill every slot, then run into the top
        apply_settings(1, 0, 0, 1);
        send_cmd(make_item(OP_START, FREQ_MIN, 0, 0, 0, 0, 0));
        repeat (22) send_cmd(make_item(OP_MEASURE, 0, 0, 15, 255, 0, 100));
        send_cmd(make_item(OP_START, 10790, 0, 0, 0, 0, 0));
        repeat (2) send_cmd(make_item(OP_MEASURE, 0, 0, 0, 255, 0, 100));
        run_phase(300);
        drain();

        // thresholds at the top; the result side holds off while commands pile up
        apply_settings(2, 15, 255, 0);
        hold_left = HOLD_OFF;
        run_phase(200);
        drain();

        apply_settings(3, 7, 128, 1);
        run_phase(300);
        drain();

        apply_settings(0, 3, 20, 1);
        run_phase(300);
        drain();

        // closing stretch at full rate
        apply_settings($urandom_range(0, 3), $urandom_range(0, 6), $urandom_range(0, 60),
                       $urandom_range(0, 1));
        idle_on = 1'b0;
        run_phase(400);
        drain();

        if (mismatches == 0 && results_due == 0)
            $display("[fm_seek_lock_scanner] OK");
        else
            $display("[fm_seek_lock_scanner] ERROR");
        $finish;
    end

endmodule
